### rtl/ddc_pkg.sv
// Shared types and constants for the deadlock detection checker.
// No dependencies; every other file of the block but ddc_ram imports this package.
package ddc_pkg;

    localparam int RES_MAX   = 4;   // resource lanes carried in a row
    localparam int VAL_W     = 8;   // width of one held or wanted count
    localparam int WORK_W    = 16;  // width of one work vector entry
    localparam int PIDX_W    = 6;   // width of the process index field
    localparam int CFG_IDX_W = 2;   // width of the register index

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_3 = 2'd3;

    typedef logic [RES_MAX-1:0][VAL_W-1:0]  t_res_vec;
    typedef logic [RES_MAX-1:0][WORK_W-1:0] t_work;

    // One process row as it arrives
    typedef struct packed {
        logic [VAL_W-1:0] held_0;
        logic [VAL_W-1:0] held_1;
        logic [VAL_W-1:0] held_2;
        logic [VAL_W-1:0] held_3;
        logic [VAL_W-1:0] wanted_0;
        logic [VAL_W-1:0] wanted_1;
        logic [VAL_W-1:0] wanted_2;
        logic [VAL_W-1:0] wanted_3;
        logic             final_row;
    } t_row_item;

    // One result item
    typedef struct packed {
        logic              system_safe;
        logic [PIDX_W-1:0] proc_index;
        logic              entry_valid;
        logic              run_end;
    } t_res_item;

    // Row as kept in the row memory
    typedef struct packed {
        t_res_vec held;
        t_res_vec wanted;
    } t_row_word;

endpackage

### rtl/ddc_row_if.sv
// Valid/ready channel carrying one process row per item.
// Depends on ddc_pkg for the payload type.
interface ddc_row_if;
    import ddc_pkg::*;

    logic      valid;
    logic      ready;
    t_row_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ddc_res_if.sv
// Valid/ready channel carrying one result item per handshake.
// Depends on ddc_pkg for the payload type.
interface ddc_res_if;
    import ddc_pkg::*;

    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ddc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module ddc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ddc_fit_unit.sv
// Shared request-fit unit: compares one row's request with the work vector
// and forms the work vector after release. Depends on ddc_pkg.
module ddc_fit_unit #(
    parameter int NUM_RES = 3
) (
    input  ddc_pkg::t_work    i_work,
    input  ddc_pkg::t_res_vec i_held,
    input  ddc_pkg::t_res_vec i_wanted,
    output logic              o_fits,
    output ddc_pkg::t_work    o_work
);
    import ddc_pkg::*;

    logic [RES_MAX-1:0] lane_ok;

    for (genvar r = 0; r < RES_MAX; r++) begin : g_lane
        if (r < NUM_RES) begin : g_used
            assign lane_ok[r] = (WORK_W'(i_wanted[r]) <= i_work[r]);
            assign o_work[r]  = i_work[r] + WORK_W'(i_held[r]);
        end else begin : g_unused
            assign lane_ok[r] = 1'b1;
            assign o_work[r]  = i_work[r];
        end
    end

    assign o_fits = &lane_ok;
endmodule

### rtl/deadlock_detection_checker.sv
// Deadlock detection checker, top level. Depends on ddc_pkg, ddc_row_if,
// ddc_res_if, ddc_ram and ddc_fit_unit.
//
// Process rows arrive one per item; a row with final_row set is stored if
// there is room and starts the check. The work vector starts from the
// available registers, and processes holding nothing start as finished.
// The check walks the stored rows in index order in passes: a finished row
// is skipped, an unfinished one is read from the row memory (S_RD), then
// the shared fit unit compares its request with work and releases its
// holdings if it fits (S_EV). Each pass ends with S_RD finding the end of
// the rows and the decision state S_DECIDE; passes repeat until every
// process is finished or a pass frees nothing, so the check takes at most
// NUM_PROCS passes. If every process started finished, one empty result is
// given; else results leave one per cycle while the output is free for a
// deadlock list, finished rows skipped in between, or, for the finish order,
// are read back from the order memory entry by entry and emitted. Rows are
// not taken while a check or its result listing is under way. The pace is
// set by the single read port of the row memory feeding the one fit unit.
module deadlock_detection_checker #(
    parameter int NUM_PROCS = 8,
    parameter int NUM_RES   = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ddc_row_if.sink                             i_row,
    ddc_res_if.source                           o_res,
    input  logic                                i_cfg_we,
    input  logic [ddc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ddc_pkg::VAL_W-1:0]           i_cfg_data
);
    import ddc_pkg::*;

    localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam logic [CNT_W-1:0] PROCS_C = CNT_W'(NUM_PROCS);

    typedef enum logic [2:0] {
        S_IDLE,     // take rows
        S_RD,       // pick next row of the pass, issue its read
        S_EV,       // test the row against work
        S_DECIDE,   // end of pass
        S_EMPTY,    // emit the empty-run result
        S_ORD_RD,   // read one finish-order entry
        S_ORD_OUT,  // emit it
        S_DL        // list deadlocked processes
    } t_state;

    t_state             r_state,  n_state;
    t_res_vec           r_avail,  n_avail;
    logic [CNT_W-1:0]   r_rows,   n_rows;   // rows stored in this run
    logic [CNT_W-1:0]   r_n,      n_n;      // rows taken into the check
    logic [CNT_W-1:0]   r_total,  n_total;  // processes finished so far
    logic [CNT_W-1:0]   r_fin,    n_fin;    // entries in the finish order
    logic [CNT_W-1:0]   r_p,      n_p;      // walk position
    logic [CNT_W-1:0]   r_left,   n_left;   // deadlocked count
    logic [CNT_W-1:0]   r_emit,   n_emit;   // deadlocked entries emitted
    logic               r_prog,   n_prog;   // pass made progress
    t_work              r_work,   n_work;
    logic [NUM_PROCS-1:0] r_done, n_done;
    logic               r_ovalid, n_ovalid;
    t_res_item          r_out,    n_out;

    // Memory ports
    logic               row_we;
    logic [IDX_W-1:0]   row_waddr;
    t_row_word          row_wdata;
    logic               row_re;
    t_row_word          row_rdata;
    logic               ord_we;
    logic               ord_re;
    logic [IDX_W-1:0]   ord_rdata;

    // Fit unit
    logic               fits;
    t_work              fit_work;

    // Incoming row
    t_row_word          in_word;
    logic               in_idle;
    logic               row_take;
    logic               slot_free;
    logic [IDX_W-1:0]   p_idx;

    assign in_word.held   = {i_row.data.held_3, i_row.data.held_2,
                             i_row.data.held_1, i_row.data.held_0};
    assign in_word.wanted = {i_row.data.wanted_3, i_row.data.wanted_2,
                             i_row.data.wanted_1, i_row.data.wanted_0};

    assign i_row.ready = (r_state == S_IDLE);
    assign row_take    = i_row.valid && (r_state == S_IDLE);
    assign slot_free   = !r_ovalid || o_res.ready;
    assign p_idx       = r_p[IDX_W-1:0];

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // A row counts as idle when it holds nothing of the resources in use
    always_comb begin
        in_idle = 1'b1;
        for (int r = 0; r < RES_MAX; r++) begin
            if (r < NUM_RES && in_word.held[r] != '0) begin
                in_idle = 1'b0;
            end
        end
    end

    ddc_ram #(
        .WIDTH ($bits(t_row_word)),
        .DEPTH (NUM_PROCS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (p_idx),
        .o_rdata (row_rdata)
    );

    // Finish order: written at r_fin during passes, read back at r_p
    ddc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PROCS)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_fin[IDX_W-1:0]),
        .i_wdata (p_idx),
        .i_re    (ord_re),
        .i_raddr (p_idx),
        .o_rdata (ord_rdata)
    );

    ddc_fit_unit #(
        .NUM_RES (NUM_RES)
    ) u_fit (
        .i_work   (r_work),
        .i_held   (row_rdata.held),
        .i_wanted (row_rdata.wanted),
        .o_fits   (fits),
        .o_work   (fit_work)
    );

    always_comb begin
        n_state  = r_state;
        n_avail  = r_avail;
        n_rows   = r_rows;
        n_n      = r_n;
        n_total  = r_total;
        n_fin    = r_fin;
        n_p      = r_p;
        n_left   = r_left;
        n_emit   = r_emit;
        n_prog   = r_prog;
        n_work   = r_work;
        n_done   = r_done;
        n_ovalid = r_ovalid && !o_res.ready;
        n_out    = r_out;

        row_we    = 1'b0;
        row_waddr = r_rows[IDX_W-1:0];
        row_wdata = in_word;
        row_re    = 1'b0;
        ord_we    = 1'b0;
        ord_re    = 1'b0;

        // Configuration writes are taken in any state
        if (i_cfg_we) begin
            n_avail[i_cfg_idx] = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (row_take) begin
                    // Store the row while there is room; mark idle rows done
                    if (r_rows < PROCS_C) begin
                        row_we                      = 1'b1;
                        n_done[r_rows[IDX_W-1:0]]   = in_idle;
                        n_total = CNT_W'(r_total + CNT_W'(in_idle));
                        n_rows  = CNT_W'(r_rows + 1'b1);
                    end
                    if (i_row.data.final_row) begin
                        n_n    = n_rows;
                        n_rows = '0;
                        n_p    = '0;
                        n_fin  = '0;
                        n_prog = 1'b0;
                        for (int r = 0; r < RES_MAX; r++) begin
                            n_work[r] = (r < NUM_RES) ? WORK_W'(r_avail[r]) : '0;
                        end
                        n_state = S_RD;
                    end
                end
            end

            S_RD: begin
                if (r_p == r_n) begin
                    n_state = S_DECIDE;
                end else if (r_done[p_idx]) begin
                    n_p = CNT_W'(r_p + 1'b1);
                end else begin
                    row_re  = 1'b1;
                    n_state = S_EV;
                end
            end

            S_EV: begin
                if (fits) begin
                    // Release the holdings and record the finish
                    n_work        = fit_work;
                    n_done[p_idx] = 1'b1;
                    ord_we        = 1'b1;
                    n_fin         = CNT_W'(r_fin + 1'b1);
                    n_total       = CNT_W'(r_total + 1'b1);
                    n_prog        = 1'b1;
                end
                n_p     = CNT_W'(r_p + 1'b1);
                n_state = S_RD;
            end

            S_DECIDE: begin
                n_p = '0;
                if (r_total == r_n) begin
                    n_state = (r_fin == '0) ? S_EMPTY : S_ORD_RD;
                end else if (r_prog) begin
                    n_prog  = 1'b0;
                    n_state = S_RD;
                end else begin
                    n_left  = CNT_W'(r_n - r_total);
                    n_emit  = '0;
                    n_state = S_DL;
                end
            end

            S_EMPTY: begin
                if (slot_free) begin
                    n_ovalid          = 1'b1;
                    n_out.system_safe = 1'b1;
                    n_out.proc_index  = '0;
                    n_out.entry_valid = 1'b0;
                    n_out.run_end     = 1'b1;
                    n_total           = '0;
                    n_state           = S_IDLE;
                end
            end

            S_ORD_RD: begin
                ord_re  = 1'b1;
                n_state = S_ORD_OUT;
            end

            S_ORD_OUT: begin
                if (slot_free) begin
                    n_ovalid          = 1'b1;
                    n_out.system_safe = 1'b1;
                    n_out.proc_index  = PIDX_W'(ord_rdata);
                    n_out.entry_valid = 1'b1;
                    n_out.run_end     = (CNT_W'(r_p + 1'b1) == r_fin);
                    n_p               = CNT_W'(r_p + 1'b1);
                    if (CNT_W'(r_p + 1'b1) == r_fin) begin
                        n_total = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ORD_RD;
                    end
                end
            end

            S_DL: begin
                // Walk the rows; every unfinished one is a deadlocked process
                if (r_done[p_idx]) begin
                    n_p = CNT_W'(r_p + 1'b1);
                end else if (slot_free) begin
                    n_ovalid          = 1'b1;
                    n_out.system_safe = 1'b0;
                    n_out.proc_index  = PIDX_W'(p_idx);
                    n_out.entry_valid = 1'b1;
                    n_out.run_end     = (CNT_W'(r_emit + 1'b1) == r_left);
                    n_emit            = CNT_W'(r_emit + 1'b1);
                    n_p               = CNT_W'(r_p + 1'b1);
                    if (CNT_W'(r_emit + 1'b1) == r_left) begin
                        n_total = '0;
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_avail  <= '0;
            r_rows   <= '0;
            r_n      <= '0;
            r_total  <= '0;
            r_fin    <= '0;
            r_p      <= '0;
            r_left   <= '0;
            r_emit   <= '0;
            r_prog   <= 1'b0;
            r_work   <= '0;
            r_done   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_avail  <= n_avail;
            r_rows   <= n_rows;
            r_n      <= n_n;
            r_total  <= n_total;
            r_fin    <= n_fin;
            r_p      <= n_p;
            r_left   <= n_left;
            r_emit   <= n_emit;
            r_prog   <= n_prog;
            r_work   <= n_work;
            r_done   <= n_done;
            r_ovalid <= n_ovalid;
        end
        r_out <= n_out;
    end
endmodule

### tb/deadlock_detection_checker_test.sv
// Self-checking bench for deadlock_detection_checker: drives process rows and
// available counts, predicts the finish order or deadlock list, checks results.
// Depends on ddc_pkg, ddc_row_if, ddc_res_if and the checker RTL.
module deadlock_detection_checker_test;
    import ddc_pkg::*;

    localparam int NUM_PROCS    = 8;
    localparam int NUM_RES      = 3;
    localparam int RANDOM_ROWS  = 140;
    localparam int SETTLE       = 40;       // quiet cycles before a register write
    localparam int LIMIT_CYCLES = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Bench-owned drive variables, known from time zero
    logic                 row_valid = 1'b0;
    t_row_item            row_data  = '0;
    logic                 res_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [VAL_W-1:0]     cfg_data  = '0;

    ddc_row_if row_ch ();
    ddc_res_if res_ch ();

    assign row_ch.valid = row_valid;
    assign row_ch.data  = row_data;
    assign res_ch.ready = res_ready;

    deadlock_detection_checker #(
        .NUM_PROCS (NUM_PROCS),
        .NUM_RES   (NUM_RES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_row      (row_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Rows waiting to be driven, and results still owed by the block
    t_row_item pending_rows [$];
    t_res_item owed_results [$];

    int  rows_queued = 0;
    int  rows_taken  = 0;
    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  row_taken   = 1'b0;
    bit  calm        = 1'b0;    // no idling on either side while set

    // Predictor state: stored rows, row count and the available registers
    logic [VAL_W-1:0] held_mem  [NUM_PROCS][RES_MAX];
    logic [VAL_W-1:0] want_mem  [NUM_PROCS][RES_MAX];
    logic [VAL_W-1:0] avail_reg [RES_MAX] = '{default: '0};
    int               rows_held = 0;

    // Store one accepted row; on the final row run the detection over the
    // stored rows and queue the finish order or the deadlocked processes.
    task automatic take_row(input t_row_item it);
        logic [WORK_W-1:0] work  [RES_MAX];
        bit                done  [NUM_PROCS];
        int                order [$];
        int                n, freed, p, r;
        bit                fits, moved, holds;
        t_res_item         res;
        // Rows beyond the store are dropped, but a final one still counts
        if (rows_held < NUM_PROCS) begin
            held_mem[rows_held] = '{it.held_0, it.held_1, it.held_2, it.held_3};
            want_mem[rows_held] = '{it.wanted_0, it.wanted_1, it.wanted_2, it.wanted_3};
            rows_held++;
        end
        if (it.final_row) begin
            n         = rows_held;
            rows_held = 0;
            freed     = 0;
            for (r = 0; r < RES_MAX; r++)
                work[r] = (r < NUM_RES) ? WORK_W'(avail_reg[r]) : '0;
            // A process holding nothing in the used lanes starts as finished
            for (p = 0; p < NUM_PROCS; p++) begin
                holds = 1'b0;
                if (p < n)
                    for (r = 0; r < NUM_RES; r++)
                        if (held_mem[p][r] != '0)
                            holds = 1'b1;
                done[p] = !holds;
                if (p < n && !holds)
                    freed++;
            end
            // Passes in index order until all finish or a pass frees nothing
            do begin
                moved = 1'b0;
                for (p = 0; p < n; p++) begin
                    if (!done[p]) begin
                        fits = 1'b1;
                        for (r = 0; r < NUM_RES; r++)
                            if (WORK_W'(want_mem[p][r]) > work[r])
                                fits = 1'b0;
                        if (fits) begin
                            for (r = 0; r < NUM_RES; r++)
                                work[r] = work[r] + WORK_W'(held_mem[p][r]);
                            done[p] = 1'b1;
                            order.push_back(p);
                            freed++;
                            moved = 1'b1;
                        end
                    end
                end
            end while (moved && freed < n);

            if (freed >= n) begin
                if (order.size() == 0) begin
                    // Nobody held anything: a single empty entry
                    res.system_safe = 1'b1;
                    res.proc_index  = '0;
                    res.entry_valid = 1'b0;
                    res.run_end     = 1'b1;
                    owed_results.push_back(res);
                end else begin
                    foreach (order[k]) begin
                        res.system_safe = 1'b1;
                        res.proc_index  = PIDX_W'(order[k]);
                        res.entry_valid = 1'b1;
                        res.run_end     = (k == order.size() - 1);
                        owed_results.push_back(res);
                    end
                end
            end else begin
                for (p = 0; p < n; p++) begin
                    if (!done[p]) begin
                        res.system_safe = 1'b0;
                        res.proc_index  = PIDX_W'(p);
                        res.entry_valid = 1'b1;
                        res.run_end     = 1'b0;
                        owed_results.push_back(res);
                    end
                end
                owed_results[owed_results.size() - 1].run_end = 1'b1;
            end
        end
    endtask

    // Monitor: check results first, then take rows, all on the rising edge
    always @(posedge i_clk) begin : monitor
        t_res_item want, got;
        cycle_count++;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (owed_results.size() == 0) begin
                    $error("result with nothing owed: safe=%0d index=%0d",
                           got.system_safe, got.proc_index);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.system_safe !== want.system_safe) begin
                        $error("system_safe: expected %0d, got %0d",
                               want.system_safe, got.system_safe);
                        fail_count++;
                    end
                    if (got.proc_index !== want.proc_index) begin
                        $error("proc_index: expected %0d, got %0d",
                               want.proc_index, got.proc_index);
                        fail_count++;
                    end
                    if (got.entry_valid !== want.entry_valid) begin
                        $error("entry_valid: expected %0d, got %0d",
                               want.entry_valid, got.entry_valid);
                        fail_count++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $error("run_end: expected %0d, got %0d",
                               want.run_end, got.run_end);
                        fail_count++;
                    end
                end
            end
            row_taken <= row_ch.valid && row_ch.ready;
            if (row_ch.valid && row_ch.ready) begin
                take_row(row_ch.data);
                rows_taken++;
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: advance to the next row once the current one is taken, idling
    // at random; hold the row otherwise. Stall the result side at random.
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            row_valid <= 1'b0;
        end else if (!row_valid || row_taken) begin
            if (pending_rows.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                row_data  <= pending_rows.pop_front();
                row_valid <= 1'b1;
            end else begin
                row_valid <= 1'b0;
            end
        end
        res_ready <= i_rst_n && (calm || $urandom_range(99) >= 32);
    end

    function automatic t_row_item row_of(input logic [VAL_W-1:0] h0, h1, h2, h3,
                                         input logic [VAL_W-1:0] w0, w1, w2, w3,
                                         input bit last);
        t_row_item it;
        it = '{h0, h1, h2, h3, w0, w1, w2, w3, last};
        return it;
    endfunction

    // Narrow rows keep counts small so that runs mix finishing and blocking;
    // wide rows take the full range. The unused lane is always random.
    function automatic t_row_item random_row(input bit narrow, input bit last);
        t_row_item it;
        int        top_h, top_w;
        top_h = narrow ? 3 : 255;
        top_w = narrow ? 4 : 255;
        it.held_0    = VAL_W'($urandom_range(top_h));
        it.held_1    = VAL_W'($urandom_range(top_h));
        it.held_2    = VAL_W'($urandom_range(top_h));
        it.held_3    = VAL_W'($urandom_range(255));
        it.wanted_0  = VAL_W'($urandom_range(top_w));
        it.wanted_1  = VAL_W'($urandom_range(top_w));
        it.wanted_2  = VAL_W'($urandom_range(top_w));
        it.wanted_3  = VAL_W'($urandom_range(255));
        it.final_row = last;
        // Some processes hold nothing and start as finished
        if (narrow && $urandom_range(4) == 0) begin
            it.held_0 = '0;
            it.held_1 = '0;
            it.held_2 = '0;
        end
        return it;
    endfunction

    task automatic queue_row(input t_row_item it);
        pending_rows.push_back(it);
        rows_queued++;
    endtask

    // One run of rows ending in a final row: mostly well-formed small runs,
    // some overfilling the store, the rest wide noise with stray final rows
    task automatic queue_random_run();
        int kind, n, i;
        kind = $urandom_range(99);
        if (kind < 85)
            n = (kind < 70) ? $urandom_range(1, NUM_PROCS)
                            : $urandom_range(NUM_PROCS + 1, NUM_PROCS + 3);
        else
            n = $urandom_range(1, NUM_PROCS);
        for (i = 0; i < n; i++) begin
            if (kind < 85)
                queue_row(random_row(1'b1, i == n - 1));
            else
                queue_row(random_row(1'b0, i == n - 1 || $urandom_range(7) == 0));
        end
    endtask

    task automatic write_avail(input logic [CFG_IDX_W-1:0] idx,
                               input logic [VAL_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        avail_reg[idx] = value;
    endtask

    task automatic set_avail(input logic [VAL_W-1:0] a0, a1, a2, a3);
        write_avail(CFG_AVAIL_0, a0);
        write_avail(CFG_AVAIL_1, a1);
        write_avail(CFG_AVAIL_2, a2);
        write_avail(CFG_AVAIL_3, a3);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued row is taken and every result has arrived
    task automatic wait_idle();
        while (rows_taken != rows_queued || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int phase, first_random, mode, i;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty run: only the unused lane is non-zero, so nobody holds anything
        set_avail(8'd0, 8'd0, 8'd0, 8'd0);
        queue_row(row_of(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
        wait_idle();

        // Deadlock with nothing available
        queue_row(row_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0));
        queue_row(row_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1));
        wait_idle();

        // Full counts everywhere: safe in index order
        set_avail(8'd255, 8'd255, 8'd255, 8'd255);
        queue_row(row_of(8'd255, 8'd255, 8'd255, 8'd255,
                         8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
        queue_row(row_of(8'd255, 8'd255, 8'd255, 8'd255,
                         8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        wait_idle();

        // Second pass needed: process 1 frees what process 0 waits for
        set_avail(8'd1, 8'd0, 8'd0, 8'd0);
        queue_row(row_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0));
        queue_row(row_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0));
        queue_row(row_of(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
        wait_idle();

        // Partial deadlock: one finishes, one waits on an impossible request
        set_avail(8'd3, 8'd0, 8'd0, 8'd0);
        queue_row(row_of(8'd1, 8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 1'b0));
        queue_row(row_of(8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1));
        wait_idle();

        // Overfilled store: rows past the last slot are dropped
        set_avail(8'd2, 8'd2, 8'd2, 8'd0);
        for (i = 0; i < NUM_PROCS + 2; i++)
            queue_row(row_of(VAL_W'(i % 3), 8'd1, 8'd0, 8'd0,
                             VAL_W'(i % 4), 8'd2, 8'd1, 8'd0, i == NUM_PROCS + 1));
        wait_idle();

        // Random phases, with one stretch of no idling on either side
        phase        = 0;
        first_random = rows_queued;
        while (rows_queued - first_random < RANDOM_ROWS) begin
            calm <= (phase >= 8 && phase < 14);
            if (phase % 3 == 0) begin
                mode = $urandom_range(9);
                if (mode == 0)
                    set_avail(8'd0, 8'd0, 8'd0, 8'd0);
                else if (mode == 1)
                    set_avail(8'd255, 8'd255, 8'd255, 8'd255);
                else if (mode == 2)
                    set_avail(VAL_W'($urandom_range(255)), VAL_W'($urandom_range(255)),
                              VAL_W'($urandom_range(255)), VAL_W'($urandom_range(255)));
                else
                    set_avail(VAL_W'($urandom_range(4)), VAL_W'($urandom_range(4)),
                              VAL_W'($urandom_range(4)), VAL_W'($urandom_range(255)));
            end
            repeat ($urandom_range(1, 3)) queue_random_run();
            wait_idle();
            phase++;
        end

        if (fail_count == 0 && owed_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
